FILE: rtl/core/omw_pkg.sv
// Shared types, codes and register defaults for the single-wire bus master.
package omw_pkg;

   localparam int CsrCount      = 7;
   localparam int CsrIndexWidth = $clog2(CsrCount);
   localparam int CsrDataWidth  = 10;
   localparam int TimerWidth    = 10;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_RESET = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_PRESENCE = 2'd1,
      STATUS_REJECT   = 2'd2
   } status_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_RESET_LOW     = 3'd0,
      CSR_RESET_RELEASE = 3'd1,
      CSR_PRES_WAIT     = 3'd2,
      CSR_PRES_LOW      = 3'd3,
      CSR_SLOT_SHORT    = 3'd4,
      CSR_SLOT_LONG     = 3'd5,
      CSR_READ_RECOVERY = 3'd6
   } csr_index_type;

   typedef enum logic [9:0] {
      PH_IDLE      = 10'b00_0000_0001,
      PH_RST_LOW   = 10'b00_0000_0010,
      PH_RST_REL   = 10'b00_0000_0100,
      PH_PRES_WAIT = 10'b00_0000_1000,
      PH_PRES_LOW  = 10'b00_0001_0000,
      PH_WR_FIRST  = 10'b00_0010_0000,
      PH_WR_SECOND = 10'b00_0100_0000,
      PH_RD_LOW    = 10'b00_1000_0000,
      PH_RD_SAMPLE = 10'b01_0000_0000,
      PH_RD_REC    = 10'b10_0000_0000
   } phase_type;

   localparam logic [9:0] RESET_LOW_DEFAULT     = 10'd750;
   localparam logic [7:0] RESET_RELEASE_DEFAULT = 8'd15;
   localparam logic [7:0] PRES_WAIT_DEFAULT     = 8'd200;
   localparam logic [7:0] PRES_LOW_DEFAULT      = 8'd240;
   localparam logic [3:0] SLOT_SHORT_DEFAULT    = 4'd2;
   localparam logic [6:0] SLOT_LONG_DEFAULT     = 7'd60;
   localparam logic [6:0] READ_RECOVERY_DEFAULT = 7'd50;

   typedef struct packed {
      logic [9:0] reset_low_time;
      logic [7:0] reset_release_time;
      logic [7:0] presence_wait_limit;
      logic [7:0] presence_low_limit;
      logic [3:0] slot_short_time;
      logic [6:0] slot_long_time;
      logic [6:0] read_recovery_time;
   } cfg_type;

   typedef struct packed {
      phase_type             phase;
      logic [TimerWidth-1:0] phase_timer;
      logic [2:0]            bit_index;
      logic [7:0]            shift_byte;
   } state_type;

   typedef struct packed {
      logic       pull_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_value;
      status_type status;
   } result_type;

endpackage

FILE: rtl/core/omw_csr.sv
// Timing configuration registers of the single-wire bus master.
module omw_csr
   import omw_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wen,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_RESET_LOW:     cfg_in.reset_low_time     = csr_wdata[9:0];
            CSR_RESET_RELEASE: cfg_in.reset_release_time = csr_wdata[7:0];
            CSR_PRES_WAIT:     cfg_in.presence_wait_limit = csr_wdata[7:0];
            CSR_PRES_LOW:      cfg_in.presence_low_limit = csr_wdata[7:0];
            CSR_SLOT_SHORT:    cfg_in.slot_short_time    = csr_wdata[3:0];
            CSR_SLOT_LONG:     cfg_in.slot_long_time     = csr_wdata[6:0];
            CSR_READ_RECOVERY: cfg_in.read_recovery_time = csr_wdata[6:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_time      <= RESET_LOW_DEFAULT;
         cfg_ff.reset_release_time  <= RESET_RELEASE_DEFAULT;
         cfg_ff.presence_wait_limit <= PRES_WAIT_DEFAULT;
         cfg_ff.presence_low_limit  <= PRES_LOW_DEFAULT;
         cfg_ff.slot_short_time     <= SLOT_SHORT_DEFAULT;
         cfg_ff.slot_long_time      <= SLOT_LONG_DEFAULT;
         cfg_ff.read_recovery_time  <= READ_RECOVERY_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/omw_step.sv
// Next-state and result logic for one beat of the single-wire bus master.
module omw_step
   import omw_pkg::*;
(
   input  cmd_type    cmd,
   input  logic [7:0] write_value,
   input  logic       line_level,
   input  cfg_type    cfg,
   input  state_type  state,
   output state_type  state_next,
   output result_type result
);

   logic                  bit_now;
   logic [TimerWidth-1:0] len;
   logic [TimerWidth:0]   timer_inc;
   logic                  expired;
   logic                  done;
   logic [7:0]            rval;
   status_type            status;
   state_type             ns;

   assign bit_now   = state.shift_byte[0];
   assign timer_inc = {1'b0, state.phase_timer} + {{TimerWidth{1'b0}}, 1'b1};

   always_comb begin
      case (state.phase)
         PH_RST_LOW:   len = cfg.reset_low_time;
         PH_RST_REL:   len = {2'b0, cfg.reset_release_time};
         PH_PRES_WAIT: len = {2'b0, cfg.presence_wait_limit};
         PH_PRES_LOW:  len = {2'b0, cfg.presence_low_limit};
         PH_WR_FIRST:  len = bit_now ? {6'b0, cfg.slot_short_time} : {3'b0, cfg.slot_long_time};
         PH_WR_SECOND: len = bit_now ? {3'b0, cfg.slot_long_time} : {6'b0, cfg.slot_short_time};
         PH_RD_LOW:    len = {6'b0, cfg.slot_short_time};
         PH_RD_REC:    len = {3'b0, cfg.read_recovery_time};
         default:      len = '0;
      endcase
   end

   assign expired = timer_inc >= {1'b0, len};

   always_comb begin
      ns     = state;
      done   = 1'b0;
      rval   = '0;
      status = STATUS_OK;
      if (cmd != CMD_TICK) begin
         if (state.phase != PH_IDLE) begin
            status = STATUS_REJECT;
         end else begin
            ns.phase_timer = '0;
            ns.bit_index   = '0;
            case (cmd)
               CMD_RESET: begin
                  ns.phase     = PH_RST_LOW;
                  ns.bit_index = state.bit_index;
               end
               CMD_WRITE: begin
                  ns.phase      = PH_WR_FIRST;
                  ns.shift_byte = write_value;
               end
               default: begin
                  ns.phase      = PH_RD_LOW;
                  ns.shift_byte = '0;
               end
            endcase
         end
      end else begin
         // advance the timer; a phase end resets it to zero, and idle holds it
         if (expired) begin
            ns.phase_timer = '0;
         end else begin
            ns.phase_timer = timer_inc[TimerWidth-1:0];
         end
         case (state.phase)
            PH_IDLE: ns.phase_timer = state.phase_timer;
            PH_RST_LOW: begin
               if (expired) ns.phase = PH_RST_REL;
            end
            PH_RST_REL: begin
               if (expired) ns.phase = PH_PRES_WAIT;
            end
            PH_PRES_WAIT: begin
               if (!line_level) begin
                  ns.phase       = PH_PRES_LOW;
                  ns.phase_timer = '0;
               end else if (expired) begin
                  ns.phase = PH_IDLE;
                  done     = 1'b1;
                  status   = STATUS_PRESENCE;
               end
            end
            PH_PRES_LOW: begin
               if (line_level) begin
                  ns.phase       = PH_IDLE;
                  ns.phase_timer = '0;
                  done           = 1'b1;
               end else if (expired) begin
                  ns.phase = PH_IDLE;
                  done     = 1'b1;
                  status   = STATUS_PRESENCE;
               end
            end
            PH_WR_FIRST: begin
               if (expired) ns.phase = PH_WR_SECOND;
            end
            PH_WR_SECOND: begin
               if (expired) begin
                  ns.shift_byte = {1'b0, state.shift_byte[7:1]};
                  if (state.bit_index == 3'd7) begin
                     ns.bit_index = '0;
                     ns.phase     = PH_IDLE;
                     done         = 1'b1;
                  end else begin
                     ns.bit_index = state.bit_index + 3'd1;
                     ns.phase     = PH_WR_FIRST;
                  end
               end
            end
            PH_RD_LOW: begin
               if (expired) ns.phase = PH_RD_SAMPLE;
            end
            PH_RD_SAMPLE: begin
               ns.shift_byte  = {line_level, state.shift_byte[7:1]};
               ns.phase       = PH_RD_REC;
               ns.phase_timer = '0;
            end
            PH_RD_REC: begin
               if (expired) begin
                  if (state.bit_index == 3'd7) begin
                     ns.bit_index = '0;
                     ns.phase     = PH_IDLE;
                     done         = 1'b1;
                     rval         = state.shift_byte;
                  end else begin
                     ns.bit_index = state.bit_index + 3'd1;
                     ns.phase     = PH_RD_LOW;
                  end
               end
            end
            default: begin
               ns.phase       = PH_IDLE;
               ns.phase_timer = '0;
            end
         endcase
      end
   end

   assign state_next        = ns;
   assign result.pull_low   = (ns.phase == PH_RST_LOW) || (ns.phase == PH_WR_FIRST)
                              || (ns.phase == PH_RD_LOW);
   assign result.busy_res   = ns.phase != PH_IDLE;
   assign result.done_res   = done;
   assign result.read_value = rval;
   assign result.status     = status;

endmodule

FILE: rtl/core/one_wire_master.sv
// Single-wire bus master: tick-paced reset/presence, byte write and byte read sequencer.
//
//   channel | direction | handshake         | beat
//   req_    | in        | req_valid/stall   | cmd, write_value, line_level
//   rsp_    | out       | rsp_valid/stall   | pull_low, busy_res, done_res, read_value, status
//   csr_    | in        | csr_wen           | csr_index, csr_wdata
//
// One beat per cycle sustained while the response side does not stall; a request beat
// held in the input register is offered as a response once it passes into the response register.
// The input register feeds the step logic; the sequencer state and response register
// update together when the response register is free.
// Synchronous reset loads the register defaults, returns the sequencer to idle and
// empties both registers. A stalled response holds; the request side stalls only
// while its register is full and cannot advance.
module one_wire_master
   import omw_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_cmd,
   input  logic [7:0]               req_write_value,
   input  logic                     req_line_level,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_pull_low,
   output logic                     rsp_busy_res,
   output logic                     rsp_done_res,
   output logic [7:0]               rsp_read_value,
   output logic [1:0]               rsp_status,
   input  logic                     csr_wen,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   cfg_type    cfg;
   state_type  state_ff;
   state_type  state_in;
   result_type result;
   result_type rsp_ff;

   logic       in_valid_ff;
   logic       in_valid_in;
   cmd_type    in_cmd_ff;
   logic [7:0] in_wval_ff;
   logic       in_line_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       advance;
   logic       accept;

   omw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   omw_step u_step (
      .cmd         (in_cmd_ff),
      .write_value (in_wval_ff),
      .line_level  (in_line_ff),
      .cfg         (cfg),
      .state       (state_ff),
      .state_next  (state_in),
      .result      (result)
   );

   assign advance      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign accept       = req_valid && !req_stall;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{phase: PH_IDLE, phase_timer: '0, bit_index: '0, shift_byte: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_cmd_ff  <= cmd_type'(req_cmd);
         in_wval_ff <= req_write_value;
         in_line_ff <= req_line_level;
      end
      if (advance) rsp_ff <= result;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pull_low   = rsp_ff.pull_low;
   assign rsp_busy_res   = rsp_ff.busy_res;
   assign rsp_done_res   = rsp_ff.done_res;
   assign rsp_read_value = rsp_ff.read_value;
   assign rsp_status     = rsp_ff.status;

endmodule
